[rtl/core/dsr_pkg.sv]
package dsr_pkg;

  localparam logic [10:0] ExpMax  = 11'h7ff;
  localparam int          ExpBias = 1023;
  localparam logic [63:0] DefaultNan = 64'hfff8000000000000;
  localparam logic [63:0] QuietBit   = 64'h0008000000000000;
  localparam int          RootBits   = 54;

  // job handed from front to back
  typedef struct packed {
    logic        special;  // result known, no recurrence
    logic [63:0] bits;     // special result
    logic [53:0] rad;      // radicand significand, possibly shifted left
    logic [10:0] exp;      // biased result exponent before round carry
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRun,
    BkPack
  } bk_state_e;

endpackage

[rtl/core/dsr_front.sv]
module dsr_front import dsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [63:0] operand_bits_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);

  logic        valid_q;
  job_t        job_q, job_d;
  logic        neg;
  logic [10:0] ef;
  logic [51:0] frac;
  logic [5:0]  lz;
  logic [52:0] m;
  logic [12:0] u;   // t + 1100, always nonnegative

  assign neg  = operand_bits_i[63];
  assign ef   = operand_bits_i[62:52];
  assign frac = operand_bits_i[51:0];

  // leading-zero count over the fraction
  always_comb begin
    lz = 6'd52;
    for (int k = 0; k < 52; k++) begin
      if (frac[k]) lz = 6'(51 - k);
    end
  end

  // unpack and classify
  always_comb begin
    job_d = '0;
    if (ef == 11'd0) begin
      m = 53'(frac) << (lz + 6'd1);
      u = 13'(77) - 13'(lz);   // -1022 - (lz+1) + 1100
    end else begin
      m = {1'b1, frac};
      u = 13'(ef) + 13'(1100 - ExpBias);
    end
    job_d.rad = u[0] ? {m, 1'b0} : {1'b0, m};
    job_d.exp = 11'((u >> 1) - 13'd550 + 13'(ExpBias));
    if (ef == ExpMax) begin
      job_d.special = 1'b1;
      if (frac != '0)  job_d.bits = operand_bits_i | QuietBit;
      else if (neg)    job_d.bits = DefaultNan;
      else             job_d.bits = operand_bits_i;
    end else if (ef == 11'd0 && frac == '0) begin
      job_d.special = 1'b1;
      job_d.bits = operand_bits_i;
    end else if (neg) begin
      job_d.special = 1'b1;
      job_d.bits = DefaultNan;
    end
  end

  assign full_o      = valid_q && !job_ready_i;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  // one-entry queue toward the back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && !full_o) begin
      valid_q <= 1'b1;
    end else if (job_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) job_q <= job_d;
  end

endmodule

[rtl/core/dsr_back.sv]
module dsr_back import dsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [63:0] root_bits_o
);

  bk_state_e   state_q, state_d;
  logic [53:0] rad_q;
  logic [10:0] exp_q;
  logic [56:0] rem_q, rem_d;
  logic [53:0] root_q, root_d;
  logic [5:0]  cnt_q;
  logic        out_valid_q;
  logic [63:0] out_q;
  logic        take, start, res_load;
  logic [56:0] rem_sh, trial;
  logic [52:0] sig, sig_r;
  logic        rnd;
  logic [63:0] packed_res;

  // one recurrence step: bring down a pair and try a one
  always_comb begin
    rem_sh = {rem_q[54:0], rad_q[53:52]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[52:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[52:0], 1'b0};
    end
  end

  // round to nearest even and pack
  always_comb begin
    sig   = root_q[53:1];
    rnd   = root_q[0] && (rem_q != '0 || sig[0]);
    sig_r = sig + 53'(rnd);
    if (rnd && sig == '1) packed_res = {1'b0, exp_q + 11'd1, 52'd0};
    else                  packed_res = {1'b0, exp_q, sig_r[51:0]};
  end

  assign take     = out_valid_q && pop_i;
  assign res_load = !out_valid_q || pop_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    start       = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (job_valid_i) begin
          if (job_i.special) begin
            job_ready_o = res_load;
          end else begin
            job_ready_o = 1'b1;
            start       = 1'b1;
            state_d     = BkRun;
          end
        end
      end
      BkRun: begin
        if (cnt_q == 6'(RootBits - 1)) state_d = BkPack;
      end
      BkPack: begin
        if (res_load) state_d = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (start) cnt_q <= '0;
      else if (state_q == BkRun) cnt_q <= cnt_q + 6'd1;
      if ((state_q == BkPack && res_load) ||
          (state_q == BkIdle && job_valid_i && job_i.special && res_load)) begin
        out_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      rad_q  <= job_i.rad;
      exp_q  <= job_i.exp;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == BkRun) begin
      rad_q  <= {rad_q[51:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
    if (state_q == BkPack && res_load) out_q <= packed_res;
    else if (state_q == BkIdle && job_valid_i && job_i.special && res_load)
      out_q <= job_i.bits;
  end

  assign empty_o     = !out_valid_q;
  assign root_bits_o = out_q;

endmodule

[rtl/core/double_square_root.sv]
// channel | direction | handshake   | payload
// input   | in        | push / full | operand_bits_i [63:0]
// result  | out       | empty / pop | root_bits_o [63:0]
//
// a regular operand is held in the front stage until the back loads it,
// then runs through 54 steps of the radix-2 restoring recurrence (one root
// bit per cycle) and one step to round and pack; the back takes a new
// regular item only once the last is packed. zeros, infinities, NaNs and
// negatives pass from the front register straight into the result register.
// reset (rst_ni low) empties all stages; no clearing pass.
// the front holds one classified item while the back iterates; a full
// result register stalls the back, and then the front fills and raises full.
module double_square_root import dsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [63:0] operand_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] root_bits_o
);

  logic job_valid, job_ready;
  job_t job;

  dsr_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .operand_bits_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  dsr_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .empty_o(empty), .pop_i(pop), .root_bits_o
  );

  // a regular root is always positive
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_back.state_q == BkPack) |-> !u_back.packed_res[63])
    else $error("negative packed root");

  // result register is never overwritten while still waiting
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(root_bits_o)))
    else $error("waiting result lost");

  // the step counter runs only during the recurrence
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_back.state_q == BkRun) |-> (u_back.cnt_q < 6'(RootBits)))
    else $error("step counter overran");

endmodule
